// ===== hdl/command_table_wildcard_match_core_defines.svh =====
// Assertion macros for the command table wildcard match core.
`ifndef COMMAND_TABLE_WILDCARD_MATCH_CORE_DEFINES_SVH
`define COMMAND_TABLE_WILDCARD_MATCH_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define CTWM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define CTWM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ctwm_pkg.sv =====
// Types, constants and defaults shared by the command table wildcard match core.
package ctwm_pkg;

  localparam int ENTRIES_DEF     = 16;
  localparam int PATTERN_LEN_DEF = 32;
  localparam int CMD_LEN_DEF     = 64;

  localparam int CFG_W = 5;

  localparam logic FUNC_PATTERN = 1'b0;
  localparam logic FUNC_COMMAND = 1'b1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_EQ     = 8'h3D;

  typedef struct packed {
    logic       func;
    logic [3:0] entry;
    logic [4:0] position;
    logic [7:0] char_code;
    logic       last;
  } in_t;

  typedef struct packed {
    logic       matched;
    logic [3:0] entry_index;
    logic [6:0] arg_offset;
    logic       truncated;
  } out_t;

  typedef struct packed {
    logic p_zero;
    logic p_bslash;
    logic p_dot;
    logic p_star;
    logic c_brk;
    logic c_term;
    logic c_bslash;
    logic eq;
  } flags_t;

endpackage

// ===== hdl/ctwm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ctwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ctwm_char_cmp.sv =====
// Shared character compare unit: classifies a pattern byte and a command byte.
module ctwm_char_cmp (
  input  logic [7:0]      p,
  input  logic [7:0]      cc,
  output ctwm_pkg::flags_t flags
);

  always_comb begin
    flags.p_zero   = (p == ctwm_pkg::CH_NUL);
    flags.p_bslash = (p == ctwm_pkg::CH_BSLASH);
    flags.p_dot    = (p == ctwm_pkg::CH_DOT);
    flags.p_star   = (p == ctwm_pkg::CH_STAR);
    flags.c_brk    = (cc == ctwm_pkg::CH_NUL) || (cc == ctwm_pkg::CH_SPACE);
    flags.c_term   = (cc == ctwm_pkg::CH_NUL) || (cc == ctwm_pkg::CH_SPACE) ||
                     (cc == ctwm_pkg::CH_EQ);
    flags.c_bslash = (cc == ctwm_pkg::CH_BSLASH);
    flags.eq       = (p == cc);
  end

endmodule

// ===== hdl/command_table_wildcard_match_core.sv =====
// Top level of the command table wildcard match core: sequencer, stores and ports.
//
// Input channel (in_valid/in_ready/in_data) carries one request per byte. A
// pattern request (func 0) writes one byte of a table entry; a command request
// (func 1) appends one byte to the line buffer. A command request with last
// set starts the table walk; in_ready stays low until the result is loaded
// into the output register.
// The walk tests each entry for emptiness, compares its pattern with the line
// byte by byte, handles escapes and lets a trailing star take command bytes,
// then loads the result; its pace is set by the single compare unit and the
// one read port of each store.
// Output channel (out_valid/out_ready/out_data) holds one result in a register.
// Pattern and command requests are still taken while it waits; a finished walk
// waits for the register to drain when the receiver stalls.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes entries_in_use;
// cfg_ready is always high.
// Reset (rst, synchronous) clears the line state and then zeroes all
// ENTRIES * PATTERN_LEN bytes (512 by default) of the pattern store, one byte
// per cycle, with in_ready low.
module command_table_wildcard_match_core #(
  parameter int ENTRIES     = ctwm_pkg::ENTRIES_DEF,
  parameter int PATTERN_LEN = ctwm_pkg::PATTERN_LEN_DEF,
  parameter int CMD_LEN     = ctwm_pkg::CMD_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ctwm_pkg::in_t             in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ctwm_pkg::out_t            out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ctwm_pkg::CFG_W-1:0] cfg_data
);

  localparam int EW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ECW    = $clog2(ENTRIES + 1);
  localparam int LW     = (ECW > ctwm_pkg::CFG_W) ? ECW : ctwm_pkg::CFG_W;
  localparam int RW     = $clog2(PATTERN_LEN + 3);
  localparam int PIW    = $clog2(PATTERN_LEN);
  localparam int PDEPTH = ENTRIES * PATTERN_LEN;
  localparam int PAW    = $clog2(PDEPTH);
  localparam int CAW    = $clog2(CMD_LEN);
  localparam int CCW    = $clog2(CMD_LEN + 1);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_E_RD   = 4'd2;
  localparam logic [3:0] ST_E_CHK  = 4'd3;
  localparam logic [3:0] ST_L_RD   = 4'd4;
  localparam logic [3:0] ST_L_EVAL = 4'd5;
  localparam logic [3:0] ST_ESC    = 4'd6;
  localparam logic [3:0] ST_CMP    = 4'd7;
  localparam logic [3:0] ST_X_RD   = 4'd8;
  localparam logic [3:0] ST_X_EVAL = 4'd9;
  localparam logic [3:0] ST_DONE   = 4'd10;

  logic [3:0]                 state;
  logic [PAW-1:0]             clr;
  logic [ctwm_pkg::CFG_W-1:0] entries_in_use;
  logic [CCW-1:0]             count;
  logic                       overflow;
  logic [ECW-1:0]             e_idx;
  logic [RW-1:0]              r;
  logic [RW-1:0]              star;
  logic                       has_star;
  logic [CCW-1:0]             c;
  logic                       hit;
  logic                       p_oor;
  logic                       c_oor;

  logic [RW-1:0]  pidx;
  logic [PAW-1:0] pat_raddr;
  logic [PAW-1:0] pat_waddr;
  logic [7:0]     pat_wdata;
  logic           pat_we;
  logic [7:0]     pat_rdata;
  logic           cmd_we;
  logic [7:0]     cmd_rdata;
  logic [7:0]     p;
  logic [7:0]     cc;
  logic [LW-1:0]  lim;
  logic           e_done;
  logic           accept;
  logic           room;
  logic           out_free;
  logic [ECW+3:0] e_ext;
  logic [CCW+6:0] c_ext;
  ctwm_pkg::flags_t flags;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign room      = (32'(count) < CMD_LEN);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    unique case (state)
      ST_E_RD:   pidx = '0;
      ST_L_EVAL: pidx = r + RW'(1);
      ST_ESC:    pidx = r + RW'(2);
      default:   pidx = r;
    endcase
  end

  assign pat_raddr = PAW'(PAW'(e_idx[EW-1:0]) * PAW'(PATTERN_LEN)) + PAW'(pidx[PIW-1:0]);

  always_comb begin
    if (state == ST_CLEAR) begin
      pat_we    = 1'b1;
      pat_waddr = clr;
      pat_wdata = '0;
    end else begin
      pat_we    = accept && (in_data.func == ctwm_pkg::FUNC_PATTERN) &&
                  (32'(in_data.entry) < ENTRIES) && (32'(in_data.position) < PATTERN_LEN);
      pat_waddr = PAW'(PAW'(in_data.entry) * PAW'(PATTERN_LEN)) + PAW'(in_data.position);
      pat_wdata = in_data.char_code;
    end
  end

  assign cmd_we = accept && (in_data.func == ctwm_pkg::FUNC_COMMAND) && room;

  ctwm_ram #(.WIDTH(8), .DEPTH(PDEPTH)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (pat_wdata),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  ctwm_ram #(.WIDTH(8), .DEPTH(CMD_LEN)) u_cmd_ram (
    .clk   (clk),
    .we    (cmd_we),
    .waddr (count[CAW-1:0]),
    .wdata (in_data.char_code),
    .raddr (c[CAW-1:0]),
    .rdata (cmd_rdata)
  );

  assign p  = p_oor ? 8'h00 : pat_rdata;
  assign cc = c_oor ? 8'h00 : cmd_rdata;

  ctwm_char_cmp u_cmp (
    .p     (p),
    .cc    (cc),
    .flags (flags)
  );

  assign lim    = (LW'(entries_in_use) < LW'(ENTRIES)) ? LW'(entries_in_use) : LW'(ENTRIES);
  assign e_done = (LW'(e_idx) >= lim);
  assign e_ext  = {4'b0, e_idx};
  assign c_ext  = {7'b0, c};

  always_ff @(posedge clk) begin
    p_oor <= (32'(pidx) >= PATTERN_LEN);
    c_oor <= (c >= count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr            <= '0;
      entries_in_use <= '0;
      count          <= '0;
      overflow       <= 1'b0;
      out_valid      <= 1'b0;
      hit            <= 1'b0;
      has_star       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        entries_in_use <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr <= clr + PAW'(1);
          if (clr == PAW'(PDEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && (in_data.func == ctwm_pkg::FUNC_COMMAND)) begin
            if (room) begin
              count <= count + CCW'(1);
            end else begin
              overflow <= 1'b1;
            end
            if (in_data.last) begin
              e_idx <= '0;
              hit   <= 1'b0;
              state <= ST_E_RD;
            end
          end
        end
        ST_E_RD: begin
          state <= e_done ? ST_DONE : ST_E_CHK;
        end
        ST_E_CHK: begin
          if (flags.p_zero) begin
            e_idx <= e_idx + ECW'(1);
            state <= ST_E_RD;
          end else begin
            r        <= '0;
            c        <= '0;
            star     <= '0;
            has_star <= 1'b0;
            state    <= ST_L_RD;
          end
        end
        ST_L_RD: begin
          state <= ST_L_EVAL;
        end
        ST_L_EVAL: begin
          if (flags.p_zero) begin
            if (flags.c_term) begin
              hit   <= 1'b1;
              state <= ST_DONE;
            end else if (has_star) begin
              c     <= c + CCW'(1);
              state <= ST_X_RD;
            end else begin
              e_idx <= e_idx + ECW'(1);
              state <= ST_E_RD;
            end
          end else if (flags.c_brk) begin
            e_idx <= e_idx + ECW'(1);
            state <= ST_E_RD;
          end else if (flags.p_bslash) begin
            state <= ST_ESC;
          end else if (flags.eq) begin
            r     <= r + RW'(1);
            c     <= c + CCW'(1);
            state <= ST_L_RD;
          end else if (has_star) begin
            r     <= star;
            c     <= c + CCW'(1);
            state <= ST_L_RD;
          end else begin
            e_idx <= e_idx + ECW'(1);
            state <= ST_E_RD;
          end
        end
        ST_ESC: begin
          if (flags.p_dot) begin
            r     <= r + RW'(2);
            c     <= c + CCW'(1);
            state <= ST_L_RD;
          end else if (flags.p_star) begin
            r        <= r + RW'(2);
            star     <= r + RW'(2);
            has_star <= 1'b1;
            state    <= ST_CMP;
          end else if (flags.p_bslash ? flags.eq : flags.c_bslash) begin
            r     <= flags.p_bslash ? r + RW'(2) : r + RW'(1);
            c     <= c + CCW'(1);
            state <= ST_L_RD;
          end else if (has_star) begin
            r     <= star;
            c     <= c + CCW'(1);
            state <= ST_L_RD;
          end else begin
            e_idx <= e_idx + ECW'(1);
            state <= ST_E_RD;
          end
        end
        ST_CMP: begin
          if (flags.eq) begin
            r     <= r + RW'(1);
            c     <= c + CCW'(1);
            state <= ST_L_RD;
          end else begin
            r     <= star;
            c     <= c + CCW'(1);
            state <= ST_L_RD;
          end
        end
        ST_X_RD: begin
          state <= ST_X_EVAL;
        end
        ST_X_EVAL: begin
          if (flags.c_brk) begin
            hit   <= 1'b1;
            state <= ST_DONE;
          end else begin
            c     <= c + CCW'(1);
            state <= ST_X_RD;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_data.matched     <= hit;
            out_data.entry_index <= hit ? e_ext[3:0] : 4'd0;
            out_data.arg_offset  <= hit ? c_ext[6:0] : 7'd0;
            out_data.truncated   <= overflow;
            count                <= '0;
            overflow             <= 1'b0;
            state                <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/ctwm_checker.sv =====
// Port-level checker for the command table wildcard match core, with its bind.
`include "command_table_wildcard_match_core_defines.svh"

module ctwm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input ctwm_pkg::in_t              in_data,
  input logic                       out_valid,
  input logic                       out_ready,
  input ctwm_pkg::out_t             out_data
);

  `CTWM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  `CTWM_ASSERT_IMP(a_miss_zero, out_valid && !out_data.matched, (out_data.entry_index == 4'd0) && (out_data.arg_offset == 7'd0), "miss result carries nonzero index or offset")
  `CTWM_ASSERT_IMP(a_clear_busy, $fell(rst), !in_ready, "request taken before pattern store cleared")
  `CTWM_ASSERT_NXT(a_scan_busy, in_valid && in_ready && in_data.func && in_data.last, !in_ready, "request taken during table walk")
  `CTWM_ASSERT_IMP(a_result_src, $rose(out_valid), !$past(in_ready), "result appeared without a table walk")

endmodule

bind command_table_wildcard_match_core ctwm_checker u_ctwm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
